// ===== rtl/dtm_pkg.sv =====
// dtm_pkg: shared types and constants for the table-driven DFA matcher.
// Used by dtm_ctrl, dtm_datapath and dfa_table_matcher; depends on nothing.
package dtm_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned STATE_W = 6;   // width of every state field on the ports
  localparam int unsigned SYM_W   = 8;   // width of the symbol field on the ports
  localparam int unsigned S_DATA_W = 32; // 26 payload bits padded to whole bytes
  localparam int unsigned M_DATA_W = 8;  // 7 result bits padded to a byte

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_TRANS = 3'd0,
    CMD_MARK     = 3'd1,
    CMD_START    = 3'd2,
    CMD_SYMBOL   = 3'd3,
    CMD_FINISH   = 3'd4
  } cmd_e;

  // Input word payload, final_state in the top bits.
  typedef struct packed {
    logic [STATE_W-1:0] final_state;
    logic [STATE_W-1:0] to_state;
    logic [SYM_W-1:0]   symbol;
    logic [STATE_W-1:0] from_state;
  } item_t;

  // Controller to datapath.
  typedef struct packed {
    logic clr_step;   // clearing sweep writes one table row entry and one mark
    logic tbl_wr;     // write transition (datapath checks state range)
    logic mark_wr;    // set accepting mark (datapath checks state range)
    logic tbl_rd;     // read table at {current, symbol}
    logic mark_rd;    // read mark of current state
    logic cur_start;  // current state <= start state
    logic cur_next;   // current state <= table read data
    logic out_load;   // load result register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_done;   // sweep is at its last address
    logic out_free;   // result register can take a new result this cycle
  } sts_t;

endpackage

// ===== rtl/dtm_ctrl.sv =====
// dtm_ctrl: sequencer of the DFA matcher; decodes commands, runs the clearing
// sweep and times table and mark reads. Depends on dtm_pkg.
module dtm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dtm_pkg::cmd_e in_cmd_i,
  input  dtm_pkg::sts_t sts_i,
  output dtm_pkg::cmd_t cmd_o
);
  import dtm_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SYM,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   rdy_q;
  logic   accept;

  assign accept     = in_valid_i & rdy_q;
  assign in_ready_o = rdy_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd_i)
            CMD_WR_TRANS: cmd_o.tbl_wr = 1'b1;
            CMD_MARK:     cmd_o.mark_wr = 1'b1;
            CMD_START:    cmd_o.cur_start = 1'b1;
            CMD_SYMBOL: begin
              cmd_o.tbl_rd = 1'b1;
              state_d      = ST_SYM;
            end
            CMD_FINISH: begin
              cmd_o.mark_rd = 1'b1;
              state_d       = ST_FIN;
            end
            default: ; // unused codes: word dropped
          endcase
        end
      end
      ST_SYM: begin
        cmd_o.cur_next = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      rdy_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rdy_q   <= (state_d == ST_IDLE);
    end
  end

  a_sym_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_cmd_i == CMD_SYMBOL |=> state_q == ST_SYM && !in_ready_o)
    else $error("symbol word not followed by state update cycle");

  a_fin_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_cmd_i == CMD_FINISH |=> state_q == ST_FIN && cmd_o.cur_next == 1'b0)
    else $error("finish word not followed by result cycle");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded over an untaken result");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr_step |-> !accept)
    else $error("word accepted during clearing sweep");

endmodule

// ===== rtl/dtm_datapath.sv =====
// dtm_datapath: transition table and mark memories, current state, start
// register and result register of the DFA matcher. Depends on dtm_pkg.
module dtm_datapath #(
  parameter int unsigned STATE_COUNT = 64,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dtm_pkg::cmd_t                 cmd_i,
  output dtm_pkg::sts_t                 sts_o,
  input  dtm_pkg::item_t                item_i,
  input  logic                          cfg_we_i,
  input  logic [dtm_pkg::STATE_W-1:0]   cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_o_taken_i,
  output logic                          out_accepted_o,
  output logic [dtm_pkg::STATE_W-1:0]   out_end_state_o
);
  import dtm_pkg::*;

  localparam int unsigned SW        = $clog2(STATE_COUNT);
  localparam int unsigned SWX       = (SW > STATE_W) ? SW : STATE_W;
  localparam int unsigned AW        = SW + SYMBOL_BITS;
  localparam int unsigned TBL_DEPTH = STATE_COUNT << SYMBOL_BITS;

  logic [SW-1:0] tbl_mem  [TBL_DEPTH];
  logic          mark_mem [STATE_COUNT];

  logic [AW-1:0]          clr_cnt_q;
  logic [SW-1:0]          cur_q;
  logic [STATE_W-1:0]     start_q;
  logic [SW-1:0]          tbl_rd_q;
  logic                   mark_rd_q;
  logic                   out_vld_q;
  logic                   out_acc_q;
  logic [STATE_W-1:0]     out_end_q;

  logic [SWX-1:0]         from_x, next_x, fin_x, start_x, cur_x;
  logic                   from_ok, next_ok, fin_ok, start_ok;
  logic                   tbl_we, mark_we;
  logic [AW-1:0]          tbl_wa, tbl_ra;
  logic [SW-1:0]          tbl_wd, mark_wa;
  logic                   mark_wd;
  logic [SYMBOL_BITS-1:0] sym;

  assign from_x  = SWX'(item_i.from_state);
  assign next_x  = SWX'(item_i.to_state);
  assign fin_x   = SWX'(item_i.final_state);
  assign start_x = SWX'(start_q);
  assign cur_x   = SWX'(cur_q);
  assign sym     = item_i.symbol[SYMBOL_BITS-1:0];

  assign from_ok  = (32'(item_i.from_state) < STATE_COUNT);
  assign next_ok  = (32'(item_i.to_state) < STATE_COUNT);
  assign fin_ok   = (32'(item_i.final_state) < STATE_COUNT);
  assign start_ok = (32'(start_q) < STATE_COUNT);

  // Sweep has priority; controller never issues both.
  assign tbl_we  = cmd_i.clr_step | (cmd_i.tbl_wr & from_ok & next_ok);
  assign tbl_wa  = cmd_i.clr_step ? clr_cnt_q : {from_x[SW-1:0], sym};
  assign tbl_wd  = cmd_i.clr_step ? '0 : next_x[SW-1:0];
  assign tbl_ra  = {cur_q, sym};

  assign mark_we = cmd_i.clr_step | (cmd_i.mark_wr & fin_ok);
  assign mark_wa = cmd_i.clr_step ? clr_cnt_q[AW-1:SYMBOL_BITS] : fin_x[SW-1:0];
  assign mark_wd = ~cmd_i.clr_step;

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    if (cmd_i.tbl_rd) begin
      tbl_rd_q <= tbl_mem[tbl_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    if (cmd_i.mark_rd) begin
      mark_rd_q <= mark_mem[cur_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      cur_q     <= '0;
      start_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cfg_we_i) begin
        start_q <= cfg_data_i;
      end
      if (cmd_i.cur_start) begin
        cur_q <= start_ok ? start_x[SW-1:0] : '0;
      end else if (cmd_i.cur_next) begin
        cur_q <= tbl_rd_q;
      end
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_o_taken_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_acc_q <= mark_rd_q;
      out_end_q <= cur_x[STATE_W-1:0];
    end
  end

  assign sts_o.clr_done   = (clr_cnt_q == AW'(TBL_DEPTH - 1));
  assign sts_o.out_free   = ~out_vld_q | out_ready_o_taken_i;
  assign out_valid_o      = out_vld_q;
  assign out_accepted_o   = out_acc_q;
  assign out_end_state_o  = out_end_q;

  a_cur_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cur_q) < STATE_COUNT)
    else $error("current state out of range");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_o_taken_i |=> out_vld_q && $stable(out_end_q))
    else $error("untaken result lost or changed");

  a_sweep_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_step |-> !cmd_i.tbl_wr && !cmd_i.mark_wr && !cmd_i.tbl_rd)
    else $error("table access during clearing sweep");

endmodule

// ===== rtl/dfa_table_matcher.sv =====
// Transition write, mark and start words complete in ST_IDLE, so the next word can be
// taken at once; a symbol word passes through ST_SYM (registered table read, whose
// data is the next address). A finish word registers the accepting mark, then loads
// the output register in ST_FIN, waiting while the previous result is untaken. Reset
// (async, active low) starts a clearing sweep of all STATE_COUNT << SYMBOL_BITS table
// entries (16384 by default) with s_axis_tready low; configuration is always taken.
module dfa_table_matcher #(
  parameter int unsigned STATE_COUNT = 64,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration: start state
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dtm_pkg::STATE_W-1:0]     cfg_data_i,
  // input words
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [5:0] from_state, [13:6] symbol, [19:14] target state, [25:20] final_state,
  // [31:26] zero
  input  logic [dtm_pkg::S_DATA_W-1:0]    s_axis_tdata,
  // [2:0] command
  input  logic [dtm_pkg::CMD_W-1:0]       s_axis_tuser,
  // result words
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] accepted, [6:1] end_state, [7] zero
  output logic [dtm_pkg::M_DATA_W-1:0]    m_axis_tdata
);
  import dtm_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  item_t              item;
  logic               out_acc;
  logic [STATE_W-1:0] out_end;

  // Payload fields sit packed from bit 0; padding bits are ignored.
  assign item = item_t'(s_axis_tdata[$bits(item_t)-1:0]);

  // The start register can be written in any cycle.
  assign cfg_ready_o = 1'b1;

  // Sequencer: decodes the command, runs the sweep, times the memory reads.
  dtm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (cmd_e'(s_axis_tuser)),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table, marks, current state and result register.
  dtm_datapath #(
    .STATE_COUNT (STATE_COUNT),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .item_i              (item),
    .cfg_we_i            (cfg_valid_i),
    .cfg_data_i          (cfg_data_i),
    .out_valid_o         (m_axis_tvalid),
    .out_ready_o_taken_i (m_axis_tready),
    .out_accepted_o      (out_acc),
    .out_end_state_o     (out_end)
  );

  assign m_axis_tdata = {1'b0, out_end, out_acc};

endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for dfa_table_matcher, one stream in, one stream out.
// Depends on dtm_pkg (command codes, item layout, port widths) and the matcher RTL.
// A directed table is walked first, then random automata are programmed and fed strings.
module testbench;
  import dtm_pkg::*;

  // Spare command codes, ignored by the block
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;
  localparam int unsigned TBL_DEPTH   = 64 << 8;
  localparam int unsigned WORD_TARGET = 1350;
  localparam int unsigned PHASE_WORDS = 225;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned MAX_GAP     = 18;
  // clearing sweep + ~1600 words at worst gap + every verdict at worst stall, several times over
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic               acc;
    logic [STATE_W-1:0] end_st;
  } verdict_t;

  typedef struct {
    bit                 cfg_wr;   // write start state (value in st_a) instead of a word
    logic [CMD_W-1:0]   op;
    logic [STATE_W-1:0] st_a;     // from_state and final_state
    logic [SYM_W-1:0]   sym;
    logic [STATE_W-1:0] st_b;     // target state
    bit                 typed;    // verdict given by hand below
    logic               acc;
    logic [STATE_W-1:0] end_st;
  } stim_row_t;

  localparam int unsigned N_ROWS = 26;

  // Directed walk: reset state, empty strings, extremes, spare codes, unwritten entries
  stim_row_t dir_rows [N_ROWS] = '{
    '{0, CMD_FINISH,   6'd0,  8'h00, 6'd0,  1, 1'b0, 6'd0},   // straight after reset
    '{0, CMD_SYMBOL,   6'd0,  8'hFF, 6'd0,  0, 1'b0, 6'd0},   // symbol before any start
    '{0, CMD_FINISH,   6'd63, 8'hFF, 6'd63, 1, 1'b0, 6'd0},   // unwritten entry goes to 0
    '{0, CMD_MARK,     6'd0,  8'h00, 6'd0,  0, 1'b0, 6'd0},
    '{0, CMD_FINISH,   6'd0,  8'h00, 6'd0,  1, 1'b1, 6'd0},
    '{0, CMD_WR_TRANS, 6'd0,  8'hFF, 6'd63, 0, 1'b0, 6'd0},
    '{0, CMD_WR_TRANS, 6'd63, 8'h00, 6'd21, 0, 1'b0, 6'd0},
    '{0, CMD_MARK,     6'd63, 8'hFF, 6'd63, 0, 1'b0, 6'd0},
    '{0, CMD_START,    6'd63, 8'hFF, 6'd63, 0, 1'b0, 6'd0},
    '{0, CMD_SYMBOL,   6'd0,  8'hFF, 6'd0,  0, 1'b0, 6'd0},
    '{0, CMD_FINISH,   6'd0,  8'h00, 6'd0,  0, 1'b0, 6'd0},
    '{0, CMD_SYMBOL,   6'd63, 8'h00, 6'd63, 0, 1'b0, 6'd0},
    '{0, CMD_FINISH,   6'd0,  8'h00, 6'd0,  0, 1'b0, 6'd0},
    '{0, CMD_SPARE_A,  6'd63, 8'hFF, 6'd63, 0, 1'b0, 6'd0},
    '{0, CMD_SPARE_B,  6'd63, 8'hFF, 6'd63, 0, 1'b0, 6'd0},
    '{0, CMD_SPARE_C,  6'd0,  8'h00, 6'd0,  0, 1'b0, 6'd0},
    '{0, CMD_FINISH,   6'd0,  8'h00, 6'd0,  0, 1'b0, 6'd0},   // state kept after a finish
    '{0, CMD_SYMBOL,   6'd0,  8'h80, 6'd0,  0, 1'b0, 6'd0},
    '{0, CMD_FINISH,   6'd0,  8'h00, 6'd0,  0, 1'b0, 6'd0},
    '{0, CMD_START,    6'd0,  8'h00, 6'd0,  0, 1'b0, 6'd0},
    '{0, CMD_FINISH,   6'd0,  8'h00, 6'd0,  1, 1'b1, 6'd0},   // empty string, start marked
    '{1, CMD_START,    6'd63, 8'h00, 6'd0,  0, 1'b0, 6'd0},   // start state to the top
    '{0, CMD_START,    6'd0,  8'h00, 6'd0,  0, 1'b0, 6'd0},
    '{0, CMD_FINISH,   6'd0,  8'h00, 6'd0,  1, 1'b1, 6'd63},
    '{0, CMD_SYMBOL,   6'd0,  8'h00, 6'd0,  0, 1'b0, 6'd0},
    '{0, CMD_FINISH,   6'd0,  8'h00, 6'd0,  0, 1'b0, 6'd0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [STATE_W-1:0]  cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata;
  logic [CMD_W-1:0]    s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [M_DATA_W-1:0] m_axis_tdata;

  dfa_table_matcher dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Predicted automaton
  logic [STATE_W-1:0] trans_tbl [TBL_DEPTH];
  logic               accept_mark [64];
  logic [STATE_W-1:0] cur_st;
  logic [STATE_W-1:0] start_st;

  verdict_t verdicts_due [$];

  int unsigned errors;
  int unsigned words_taken;
  int unsigned spare_words;
  int unsigned verdicts_seen;
  int unsigned cfg_writes;
  int unsigned long_holds;
  int unsigned real_words;      // words with a live command code
  int unsigned hold_off_cycles;
  bit          tx_steady;
  bit          force_burst;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, want %0d (verdict %0d)", what, got, want, verdicts_seen);
    errors++;
  endtask

  // One accepted word through the automaton. With 64 states every 6-bit state is
  // in range, so the range guards on writes, marks and start all pass.
  task automatic step_dfa(input logic [CMD_W-1:0] op, input item_t it,
                          output bit has_v, output verdict_t v);
    has_v = 1'b0;
    v     = '0;
    case (op)
      CMD_WR_TRANS: trans_tbl[{it.from_state, it.symbol}] = it.to_state;
      CMD_MARK:     accept_mark[it.final_state] = 1'b1;
      CMD_START:    cur_st = start_st;
      CMD_SYMBOL:   cur_st = trans_tbl[{cur_st, it.symbol}];
      CMD_FINISH: begin
        has_v    = 1'b1;
        v.acc    = accept_mark[cur_st];
        v.end_st = cur_st;
      end
      default: ;
    endcase
  endtask

  function automatic item_t rand_item();
    item_t it;
    it.from_state  = STATE_W'($urandom_range(0, 63));
    it.symbol      = SYM_W'($urandom_range(0, 255));
    it.to_state    = STATE_W'($urandom_range(0, 63));
    it.final_state = STATE_W'($urandom_range(0, 63));
    return it;
  endfunction

  // Noise word: any of the eight codes, spare ones included
  function automatic logic [CMD_W-1:0] CMD_WIDTH_NOISE();
    return CMD_W'($urandom_range(0, 7));
  endfunction

  // Offer one word after a random gap, wait for the handshake, then predict.
  // tvalid is left high; the caller lowers it when the sender goes quiet.
  task automatic push_word(input logic [CMD_W-1:0] op, input item_t it,
                           input bit typed, input logic t_acc,
                           input logic [STATE_W-1:0] t_end);
    int unsigned gap;
    bit          has_v;
    verdict_t    v;
    verdict_t    tv;
    gap = (tx_steady || force_burst) ? 0 : $urandom_range(0, MAX_GAP);
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_DATA_W - $bits(item_t)){1'b0}}, it};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    step_dfa(op, it, has_v, v);
    tv.acc    = t_acc;
    tv.end_st = t_end;
    if (has_v) verdicts_due.insert(verdicts_due.size(), typed ? tv : v);
    words_taken++;
    if (op > CMD_FINISH) spare_words++;
    else real_words++;
  endtask

  task automatic send(input logic [CMD_W-1:0] op, input item_t it);
    push_word(op, it, 1'b0, 1'b0, '0);
  endtask

  // Sender goes quiet until every verdict is in, plus the symbol-read latency.
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_start_state(input logic [STATE_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    start_st = val;
    cfg_writes++;
  endtask

  // Result side: random stalls, steady stretches, and one long hold-off on request
  initial begin
    int unsigned stall;
    int unsigned held;
    bit          rx_steady;
    verdict_t    want;
    logic        got_acc;
    logic [STATE_W-1:0] got_end;
    rx_steady = 1'b0;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_cycles > 0) begin
        held = 0;
        m_axis_tready <= 1'b0;
        while (held < hold_off_cycles) begin
          @(posedge clk_i);
          held++;
        end
        hold_off_cycles = 0;
        long_holds++;
      end
      stall = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 29) == 0) rx_steady = !rx_steady;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got_acc = m_axis_tdata[0];
      got_end = m_axis_tdata[STATE_W:1];
      verdicts_seen++;
      if (verdicts_due.size() == 0) begin
        report_mismatch("verdict with none due, end_state", got_end, -1);
      end else begin
        want = verdicts_due.pop_front();
        if (got_acc !== want.acc) report_mismatch("accepted", got_acc, want.acc);
        if (got_end !== want.end_st) report_mismatch("end_state", got_end, want.end_st);
      end
    end
  end

  // Watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("watchdog: %0d cycles, %0d verdicts still due", cycles, verdicts_due.size());
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  initial begin
    item_t              it;
    stim_row_t          row;
    logic [STATE_W-1:0] st_pool [16];
    logic [SYM_W-1:0]   alph [8];
    int unsigned n_st, n_sym, n_tr, n_len, phase, mark_goal, phase_base;
    int unsigned pick;

    for (int i = 0; i < TBL_DEPTH; i++) trans_tbl[i] = '0;
    for (int i = 0; i < 64; i++) accept_mark[i] = 1'b0;
    cur_st          = '0;
    start_st        = '0;
    errors          = 0;
    words_taken     = 0;
    spare_words     = 0;
    verdicts_seen   = 0;
    cfg_writes      = 0;
    long_holds      = 0;
    real_words      = 0;
    hold_off_cycles = 0;
    tx_steady       = 1'b0;
    force_burst     = 1'b0;

    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the clearing sweep simply shows up as a long wait for tready

    // Directed walk
    for (int r = 0; r < N_ROWS; r++) begin
      row = dir_rows[r];
      if (row.cfg_wr) begin
        settle_idle();
        write_start_state(row.st_a);
      end else begin
        it.from_state  = row.st_a;
        it.symbol      = row.sym;
        it.to_state    = row.st_b;
        it.final_state = row.st_a;
        push_word(row.op, it, row.typed, row.acc, row.end_st);
      end
    end

    // Random automata, one per phase, each under its own start state
    phase = 0;
    while (real_words < WORD_TARGET) begin
      settle_idle();
      n_st = $urandom_range(3, 12);
      for (int i = 0; i < n_st; i++) st_pool[i] = STATE_W'($urandom_range(0, 63));
      if (phase == 0) st_pool[0] = '0;
      if (phase == 1) st_pool[0] = '1;
      write_start_state(st_pool[0]);
      n_sym = $urandom_range(1, 6);
      for (int i = 0; i < n_sym; i++) alph[i] = SYM_W'($urandom_range(0, 255));

      // program the automaton
      n_tr = $urandom_range(n_st, n_st * n_sym);
      for (int i = 0; i < n_tr; i++) begin
        it = rand_item();
        it.from_state = st_pool[$urandom_range(0, n_st - 1)];
        it.symbol     = alph[$urandom_range(0, n_sym - 1)];
        it.to_state   = st_pool[$urandom_range(0, n_st - 1)];
        send(CMD_WR_TRANS, it);
      end
      mark_goal = $urandom_range(1, 3);
      for (int i = 0; i < mark_goal; i++) begin
        it = rand_item();
        it.final_state = st_pool[$urandom_range(0, n_st - 1)];
        send(CMD_MARK, it);
      end

      // back pressure: results pile up behind a long receiver hold-off
      if (phase == 2) begin
        hold_off_cycles = LONG_HOLD;
        force_burst     = 1'b1;
        for (int i = 0; i < 40; i++) send(CMD_FINISH, rand_item());
        force_burst     = 1'b0;
      end

      phase_base = real_words;
      while (real_words - phase_base < PHASE_WORDS && real_words < WORD_TARGET) begin
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
          send(CMD_WIDTH_NOISE(), rand_item());
        end else if (pick == 1) begin
          it = rand_item();
          it.from_state = st_pool[$urandom_range(0, n_st - 1)];
          it.symbol     = alph[$urandom_range(0, n_sym - 1)];
          send(CMD_WR_TRANS, it);
        end else begin
          // a string: usually a proper start, sometimes carrying on from the last one
          if ($urandom_range(0, 9) != 0) send(CMD_START, rand_item());
          n_len = $urandom_range(0, 8);
          for (int i = 0; i < n_len; i++) begin
            it = rand_item();
            if ($urandom_range(0, 7) != 0) it.symbol = alph[$urandom_range(0, n_sym - 1)];
            send(CMD_SYMBOL, it);
          end
          send(CMD_FINISH, rand_item());
        end
      end
      phase++;
    end

    settle_idle();
    repeat (8) @(posedge clk_i);
    $display("summary: %0d words (%0d spare codes), %0d verdicts, %0d automata",
             words_taken, spare_words, verdicts_seen, phase);
    $display("summary: %0d start-state writes, %0d long receiver hold-offs, %0d mismatches",
             cfg_writes, long_holds, errors);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
